### design/mvf_pkg.sv
`timescale 1ns / 1ps

package mvf_pkg;

	localparam int NUM_VERTICES_DEF = 8;
	localparam int ROW_INDEX_W = 3;
	localparam int ROW_BITS_W = 8;
	localparam int MOTHER_W = 3;

	typedef struct packed {
		logic [ROW_INDEX_W-1:0] row_index;
		logic [ROW_BITS_W-1:0]  row_bits;
		logic                   last_row;
	} item_t;

	typedef struct packed {
		logic                found;
		logic [MOTHER_W-1:0] mother;
	} result_t;

	// row write toward the adjacency store
	typedef struct packed {
		logic                   en;
		logic [ROW_INDEX_W-1:0] idx;
		logic [ROW_BITS_W-1:0]  bits;
	} adj_wr_t;

	// search status toward the output register
	typedef struct packed {
		logic    done;
		result_t res;
	} dfs_status_t;

endpackage

### design/mvf_adj_store.sv
`timescale 1ns / 1ps

module mvf_adj_store #(
	parameter int N = mvf_pkg::NUM_VERTICES_DEF,
	localparam int SW = (N > 1) ? $clog2(N) : 1
) (
	input  logic              clk,
	input  mvf_pkg::adj_wr_t  wr,
	input  logic [SW-1:0]     rd_addr,
	output logic [N-1:0]      rd_data
);

	logic [N-1:0] mem [N];

	logic [SW+mvf_pkg::ROW_INDEX_W-1:0] idx_ext;
	logic [N+mvf_pkg::ROW_BITS_W-1:0]   bits_ext;
	logic                               in_range;

	assign idx_ext  = (SW + mvf_pkg::ROW_INDEX_W)'(wr.idx);
	assign bits_ext = (N + mvf_pkg::ROW_BITS_W)'(wr.bits);
	// rows past the last vertex are dropped
	assign in_range = (32'(wr.idx) < 32'(N));

	always_ff @(posedge clk) begin
		if (wr.en && in_range) begin
			mem[idx_ext[SW-1:0]] <= bits_ext[N-1:0];
		end
		rd_data <= mem[rd_addr];
	end

endmodule

### design/mvf_dfs.sv
`timescale 1ns / 1ps

module mvf_dfs #(
	parameter int N = mvf_pkg::NUM_VERTICES_DEF,
	localparam int SW = (N > 1) ? $clog2(N) : 1,
	localparam int DW = $clog2(N + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 launch,
	output logic                 busy,
	output logic [SW-1:0]        adj_addr,
	input  logic [N-1:0]         adj_data,
	output mvf_pkg::dfs_status_t status
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_SCAN = 7'b0000010,
		S_WAIT = 7'b0000100,
		S_EXP  = 7'b0001000,
		S_STK  = 7'b0010000,
		S_LOAD = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	state_t         state_q;
	logic [N-1:0]   visited_q;
	logic [DW-1:0]  depth_q;
	logic [DW-1:0]  v_q;
	logic [SW-1:0]  top_q;
	logic [SW-1:0]  cand_q;
	logic           pass_q;

	logic [SW-1:0]  stk_mem [N];
	logic [SW-1:0]  stk_rd_q;
	logic           stk_we;
	logic [SW-1:0]  stk_waddr;
	logic [SW-1:0]  stk_wdata;

	logic [SW-1:0]  v_idx;
	logic [DW-1:0]  depth_m1;
	logic [N-1:0]   open_set;
	logic [N-1:0]   low_bit;
	logic [SW-1:0]  k_idx;
	logic           scan_end;
	logic           root_hit;
	logic           push;
	logic [SW+mvf_pkg::MOTHER_W-1:0] cand_ext;

	assign v_idx    = v_q[SW-1:0];
	assign depth_m1 = depth_q - DW'(1);
	assign open_set = adj_data & ~visited_q;
	assign low_bit  = open_set & (~open_set + N'(1));
	assign scan_end = (v_q == DW'(N));
	assign root_hit = (state_q == S_SCAN) && !scan_end && !visited_q[v_idx];
	assign push     = (state_q == S_EXP) && (open_set != '0) && (depth_q < DW'(N));

	always_comb begin
		k_idx = '0;
		for (int i = 0; i < N; i++) begin
			if (low_bit[i]) begin
				k_idx = k_idx | SW'(i);
			end
		end
	end

	// stack write: tree root at the bottom, or a push of a new successor
	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = '0;
		stk_wdata = k_idx;
		if (state_q == S_SCAN && scan_end) begin
			stk_we    = 1'b1;
			stk_wdata = cand_q;
		end else if (root_hit) begin
			stk_we    = 1'b1;
			stk_wdata = v_idx;
		end else if (push) begin
			stk_we    = 1'b1;
			stk_waddr = depth_q[SW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		stk_rd_q <= stk_mem[depth_m1[SW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			visited_q <= '0;
			depth_q   <= '0;
			v_q       <= '0;
			top_q     <= '0;
			cand_q    <= '0;
			pass_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (launch) begin
						visited_q <= '0;
						v_q       <= '0;
						cand_q    <= '0;
						pass_q    <= 1'b0;
						state_q   <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						visited_q <= N'(1) << cand_q;
						pass_q    <= 1'b1;
						depth_q   <= DW'(1);
						top_q     <= cand_q;
						state_q   <= S_WAIT;
					end else if (visited_q[v_idx]) begin
						v_q <= v_q + DW'(1);
					end else begin
						visited_q <= visited_q | (N'(1) << v_idx);
						cand_q    <= v_idx;
						depth_q   <= DW'(1);
						top_q     <= v_idx;
						state_q   <= S_WAIT;
					end
				end
				S_WAIT: begin
					state_q <= S_EXP;
				end
				S_EXP: begin
					if (open_set != '0) begin
						visited_q <= visited_q | low_bit;
						if (push) begin
							depth_q <= depth_q + DW'(1);
							top_q   <= k_idx;
							state_q <= S_WAIT;
						end
					end else if (depth_q == DW'(1)) begin
						depth_q <= '0;
						if (pass_q) begin
							state_q <= S_FIN;
						end else begin
							v_q     <= v_q + DW'(1);
							state_q <= S_SCAN;
						end
					end else begin
						depth_q <= depth_m1;
						state_q <= S_STK;
					end
				end
				S_STK: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					top_q   <= stk_rd_q;
					state_q <= S_WAIT;
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy     = (state_q != S_IDLE);
	assign adj_addr = top_q;
	assign cand_ext = (SW + mvf_pkg::MOTHER_W)'(cand_q);

	always_comb begin
		status.done       = (state_q == S_FIN);
		status.res.found  = (visited_q == '1);
		status.res.mother = status.res.found ? cand_ext[mvf_pkg::MOTHER_W-1:0] : '0;
	end

endmodule

### design/mother_vertex_finder.sv
`timescale 1ns / 1ps

// Mother vertex finder for a directed graph of NUM_VERTICES vertices.
//
// Input channel: start / busy / item. A word is taken at a rising edge with
// start high and busy low. Each word carries one adjacency row (row_index,
// row_bits) that goes into the row store in that cycle; rows persist across
// searches. A row word without last_row gives no result, so rows can stream in
// back to back.
// A word with last_row set stores its row and then starts the search; busy
// is high until it ends. The search is a two-pass depth-first walk with an
// explicit stack: pass one covers the graph as a forest in vertex order and
// keeps the last tree root, pass two walks from that root. Every vertex step
// goes through the row store read and every pop through the stack read; done
// pulses as busy goes low again.
// Output channel: done / result. One done pulse per last_row word, result
// valid only in that cycle; found=0 reports mother=0. The receiver cannot
// stall; a new word may be taken in the cycle of the done pulse.
// Reset (arst_n low) returns to idle with no pending result; stored rows are
// undefined until written.

module mother_vertex_finder #(
	parameter int NUM_VERTICES = mvf_pkg::NUM_VERTICES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  mvf_pkg::item_t   item,
	output logic             done,
	output mvf_pkg::result_t result
);

	localparam int SW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;

	logic                 accept;
	mvf_pkg::adj_wr_t     adj_wr;
	logic [SW-1:0]        adj_addr;
	logic [NUM_VERTICES-1:0] adj_data;
	mvf_pkg::dfs_status_t status;
	logic                 done_q;
	mvf_pkg::result_t     result_q;

	// a word is taken only while the search engine is idle
	assign accept = start && !busy;

	always_comb begin
		adj_wr.en   = accept;
		adj_wr.idx  = item.row_index;
		adj_wr.bits = item.row_bits;
	end

	mvf_adj_store #(.N(NUM_VERTICES)) u_adj (
		.clk     (clk),
		.wr      (adj_wr),
		.rd_addr (adj_addr),
		.rd_data (adj_data)
	);

	// row write lands at the accept edge, before the first search read
	mvf_dfs #(.N(NUM_VERTICES)) u_dfs (
		.clk      (clk),
		.arst_n   (arst_n),
		.launch   (accept && item.last_row),
		.busy     (busy),
		.adj_addr (adj_addr),
		.adj_data (adj_data),
		.status   (status)
	);

	// result register: one-cycle strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= status.done;
		end
	end

	always_ff @(posedge clk) begin
		if (status.done) begin
			result_q <= status.res;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

### design/mvf_checker.sv
`timescale 1ns / 1ps

module mvf_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input mvf_pkg::item_t   item,
	input logic             done,
	input mvf_pkg::result_t result
);

	// result shows while the engine is already idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.found) |-> (result.mother == '0))
		else $error("mother not zero on not found");

	a_row_only: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !item.last_row) |=> (!busy && !done))
		else $error("plain row word started work");

	a_search_go: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.last_row) |=> busy)
		else $error("last row word did not start search");

	a_one_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done longer than one cycle");

endmodule

bind mother_vertex_finder mvf_checker u_mvf_checker (.*);
